/* design/kdlp_pkg.sv */
// Package: shared types and constants for the keypad debounce / long-press block.
package kdlp_pkg;

  localparam int unsigned KeyCount  = 6;
  localparam int unsigned CodeW     = 3;
  localparam int unsigned DebW      = 8;
  localparam int unsigned LongW     = 16;
  localparam int unsigned CountW    = 16;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIndexW = 1;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic [DebW-1:0]  DebResetVal  = 8'd10;
  localparam logic [LongW-1:0] LongResetVal = 16'd1000;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CFG_DEBOUNCE   = 1'b0;
  localparam logic [CfgIndexW-1:0] CFG_LONG_PRESS = 1'b1;

  // key codes
  localparam logic [CodeW-1:0] KEY_UP             = 3'd0;
  localparam logic [CodeW-1:0] KEY_DN             = 3'd1;
  localparam logic [CodeW-1:0] KEY_LT             = 3'd2;
  localparam logic [CodeW-1:0] KEY_RT             = 3'd3;
  localparam logic [CodeW-1:0] KEY_TOP_LEFT       = 3'd4;
  localparam logic [CodeW-1:0] KEY_TOP_RIGHT      = 3'd5;
  localparam logic [CodeW-1:0] KEY_TOP_RIGHT_LONG = 3'd6;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HOLD     = 2'd2
  } phase_t;

  typedef struct packed {
    logic             valid;
    logic [CodeW-1:0] code;
  } result_t;

endpackage

/* design/kdlp_fsm.sv */
// Debounce / long-press state machine with its tick counter and config registers.
module kdlp_fsm import kdlp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 tick,
  input  logic [KeyCount-1:0]  key_levels,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  output result_t              result
);

  phase_t            phase_r, phase_nxt;
  logic [CodeW-1:0]  held_r, held_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [DebW-1:0]   deb_r;
  logic [LongW-1:0]  long_r;

  logic [CountW-1:0] count_inc;
  logic              held_down;
  logic              any_down;
  logic [CodeW-1:0]  first_key;

  assign count_inc = (count_r == CountMax) ? count_r : count_r + 1'b1;
  assign held_down = ~key_levels[held_r];
  assign any_down  = ~(&key_levels);

  // priority: lowest bit wins
  always_comb begin
    first_key = KEY_UP;
    for (int k = KeyCount - 1; k >= 0; k--) begin
      if (!key_levels[k]) begin
        first_key = CodeW'(k);
      end
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (tick) begin
      case (phase_r)
        PH_DEBOUNCE: begin
          if (count_inc >= CountW'(deb_r)) begin
            phase_nxt = held_down ? PH_HOLD : PH_IDLE;
          end
        end
        PH_HOLD: begin
          if (!held_down) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          if (any_down) begin
            phase_nxt = (deb_r == '0) ? PH_HOLD : PH_DEBOUNCE;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      endcase
    end
  end

  // counter, latched key and result
  always_comb begin
    held_nxt     = held_r;
    count_nxt    = count_r;
    result.valid = 1'b0;
    result.code  = held_r;
    if (tick) begin
      case (phase_r)
        PH_DEBOUNCE: begin
          count_nxt = count_inc;
        end
        PH_HOLD: begin
          count_nxt = count_inc;
          if (!held_down) begin
            result.valid = 1'b1;
            if (held_r == KEY_TOP_RIGHT && count_inc >= long_r) begin
              result.code = KEY_TOP_RIGHT_LONG;
            end
          end
        end
        default: begin
          if (any_down) begin
            held_nxt  = first_key;
            count_nxt = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= KEY_UP;
      count_r <= '0;
      deb_r   <= DebResetVal;
      long_r  <= LongResetVal;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      count_r <= count_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEBOUNCE:   deb_r  <= cfg_data[DebW-1:0];
          CFG_LONG_PRESS: long_r <= cfg_data[LongW-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

/* design/kdlp_out_buf.sv */
// Output register with a skid stage for the key-code channel.
module kdlp_out_buf import kdlp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  result_t          push,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [CodeW-1:0] out_key_code,
  output logic             full
);

  logic             out_valid_r, out_valid_nxt;
  logic [CodeW-1:0] out_code_r, out_code_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  logic [CodeW-1:0] skid_code_r, skid_code_nxt;
  logic             pop;

  assign pop = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_code_nxt   = out_code_r;
    skid_valid_nxt = skid_valid_r;
    skid_code_nxt  = skid_code_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_code_nxt   = skid_code_r;
        skid_valid_nxt = push.valid;
        skid_code_nxt  = push.code;
      end else begin
        out_valid_nxt = push.valid;
        out_code_nxt  = push.code;
      end
    end else if (push.valid) begin
      // skid is empty here: input is stalled whenever it holds a transaction
      skid_valid_nxt = 1'b1;
      skid_code_nxt  = push.code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_code_r  <= out_code_nxt;
    skid_code_r <= skid_code_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_key_code = out_code_r;
  assign full         = skid_valid_r;

endmodule

/* design/keypad_debounce_long_press_core.sv */
// Top level: keypad debouncer with long-press detection for six active-low keys.
//
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  in      | in_valid, in_stall, in_key_levels | sample in
//  out     | out_valid, out_stall, out_key_code | code out
//  cfg     | cfg_we, cfg_index, cfg_data    | write only
//
// One tick sample is taken per cycle while in_stall is low; its key code, if any,
// is registered into the output register, or into the skid stage while that is held.
// Synchronous active-low reset: idle state, debounce 10 ticks, long press 1000.
// The skid stage absorbs one code while out_stall is high; in_stall rises only
// once both output register and skid stage are full.
module keypad_debounce_long_press_core import kdlp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KeyCount-1:0]  in_key_levels,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CodeW-1:0]     out_key_code,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  logic    tick;
  logic    buf_full;
  result_t result;

  assign in_stall = buf_full;
  assign tick     = in_valid && !buf_full;

  kdlp_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (tick),
    .key_levels (in_key_levels),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .result     (result)
  );

  kdlp_out_buf u_out_buf (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (result),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_key_code (out_key_code),
    .full         (buf_full)
  );

endmodule

/* bench/keypad_debounce_long_press_core_tb.sv */
// Testbench for keypad_debounce_long_press_core: random key ticks against a tick predictor.
module keypad_debounce_long_press_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kdlp_pkg::*;

  localparam int CycleLimit = 1_000_000;

  // Predicts key codes tick by tick and holds the codes still owed by the block.
  class key_code_board;
    phase_t               ph;
    logic [2:0]           held;
    logic [CountW-1:0]    ticks;
    logic [DebW-1:0]      deb;
    logic [LongW-1:0]     long_lim;
    logic [CodeW-1:0]     expected_codes[$];
    int                   errors;
    int                   ticks_seen;
    int                   code_hits[7];

    function new();
      ph = PH_IDLE;
      held = '0;
      ticks = '0;
      deb = DebResetVal;
      long_lim = LongResetVal;
      errors = 0;
      ticks_seen = 0;
      foreach (code_hits[i]) code_hits[i] = 0;
    endfunction

    task report(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void apply_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
      if (idx == CFG_DEBOUNCE) deb = val[DebW-1:0];
      else long_lim = val[LongW-1:0];
    endfunction

    // one accepted tick
    function void note_levels(input logic [KeyCount-1:0] lv);
      bit found;
      found = 1'b0;
      ticks_seen++;
      case (ph)
        PH_DEBOUNCE: begin
          if (ticks != CountMax) ticks++;
          // recheck looks at the latched key only
          if (ticks >= deb) ph = lv[held] ? PH_IDLE : PH_HOLD;
        end
        PH_HOLD: begin
          if (ticks != CountMax) ticks++;
          if (lv[held]) begin
            // key index and key code coincide for the six keys
            if (held == KEY_TOP_RIGHT && ticks >= long_lim)
              expected_codes.push_back(KEY_TOP_RIGHT_LONG);
            else
              expected_codes.push_back(held);
            ph = PH_IDLE;
          end
        end
        default: begin
          ph = PH_IDLE;
          for (int k = 0; k < KeyCount; k++) begin
            if (!found && !lv[k]) begin
              found = 1'b1;
              held = 3'(k);
              ticks = '0;
              ph = (deb == 0) ? PH_HOLD : PH_DEBOUNCE;
            end
          end
        end
      endcase
    endfunction

    task check_code(input logic [CodeW-1:0] code);
      logic [CodeW-1:0] want;
      if (expected_codes.size() == 0) begin
        report($sformatf("key code %0d with none outstanding", code));
      end else begin
        want = expected_codes.pop_front();
        if (code !== want) report($sformatf("key code %0d, predicted %0d", code, want));
        code_hits[want]++;
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid;
  logic                 in_stall;
  logic [KeyCount-1:0]  in_key_levels;
  logic                 out_valid;
  logic                 out_stall;
  logic [CodeW-1:0]     out_key_code;
  logic                 cfg_we;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;

  key_code_board board;
  int          items_sent = 0;
  int          settings_used = 1;
  int          cycle_count = 0;
  int          stall_left = 0;
  int          holdoff_asked = 0;
  int          holdoff_served = 0;
  int unsigned stall_roll;
  bit          calm = 1'b0;

  keypad_debounce_long_press_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_key_levels (in_key_levels),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_key_code  (out_key_code),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_code(out_key_code);
  end

  // receiver back-pressure; a requested hold-off wins over everything else
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (holdoff_served != holdoff_asked) begin
      holdoff_served++;
      stall_left = 350;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 70) begin
        out_stall <= 1'b0;
      end else if (stall_roll < 96) begin
        stall_left = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        stall_left = $urandom_range(10, 60);
        out_stall <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // caller must come straight back here if no gap was taken, or valid stays up
  task automatic send_levels(input logic [KeyCount-1:0] lv);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_key_levels <= lv;
    do @(posedge clk); while (in_stall);
    board.note_levels(lv);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_key_levels <= KeyCount'($urandom_range(0, 63));
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // bring the state machine back to idle, then wait out every owed code
  task automatic settle();
    while (board.ph != PH_IDLE) send_levels('1);
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.expected_codes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    board.apply_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_timing(input int deb, input int lp);
    // upper byte of the debounce write is junk on purpose
    cfg_write(CFG_DEBOUNCE, {8'($urandom_range(0, 255)), 8'(deb)});
    cfg_write(CFG_LONG_PRESS, 16'(lp));
    settings_used++;
  endtask

  // press, optional bounce-out at the recheck, hold, release
  task automatic key_press_run();
    int k;
    int h;
    int target;
    bit broken;
    logic [KeyCount-1:0] lv;
    while (board.ph != PH_IDLE) send_levels('1);
    k = $urandom_range(0, 7);
    if (k > 5) k = 5;
    broken = ($urandom_range(0, 99) < 15);
    lv = KeyCount'($urandom_range(0, 63));
    lv[k] = 1'b0;
    for (int j = 0; j < k; j++) lv[j] = 1'b1;
    send_levels(lv);
    if (board.deb != 0) begin
      repeat (int'(board.deb) - 1) send_levels(KeyCount'($urandom_range(0, 63)));
      lv = KeyCount'($urandom_range(0, 63));
      lv[k] = broken;
      send_levels(lv);
      if (broken) return;
    end
    h = $urandom_range(0, 6);
    if ($urandom_range(0, 9) == 0) h = $urandom_range(10, 80);
    // aim the release right around the long-press threshold
    if (k == 5 && board.long_lim <= 1500 && $urandom_range(0, 1) == 1) begin
      target = int'(board.long_lim) - 1 + int'($urandom_range(0, 2));
      h = target - int'(board.deb) - 1;
      if (h < 0) h = 0;
    end
    repeat (h) begin
      lv = KeyCount'($urandom_range(0, 63));
      lv[k] = 1'b0;
      send_levels(lv);
    end
    lv = KeyCount'($urandom_range(0, 63));
    lv[k] = 1'b1;
    send_levels(lv);
  endtask

  task automatic run_mix(input int n_items);
    int end_at;
    end_at = items_sent + n_items;
    while (items_sent < end_at) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) send_levels(KeyCount'($urandom_range(0, 63)));
      end else begin
        key_press_run();
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    board = new();
    in_valid = 1'b0;
    in_key_levels = '1;
    cfg_we = 1'b0;
    cfg_index = CFG_DEBOUNCE;
    cfg_data = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed: no keys while idle, under reset timing
    send_levels('1);
    send_levels('1);
    settle();
    // zero debounce and zero long-press limit: every key, top-right always long
    set_timing(0, 0);
    send_levels('0);
    send_levels('1);
    for (int k = 1; k < KeyCount; k++) begin
      send_levels(~(KeyCount'(1) << k));
      send_levels('1);
    end
    settle();
    set_timing(0, 2);
    send_levels(6'h1F);
    send_levels('1);
    send_levels(6'h1F);
    send_levels(6'h1F);
    send_levels('1);
    settle();
    // key gone at the recheck, and other keys ignored during debounce
    set_timing(2, 2);
    send_levels(6'h3B);
    send_levels(6'h00);
    send_levels(6'h3F);
    send_levels(6'h3F);
    send_levels(6'h3B);
    send_levels(6'h3F);
    send_levels(6'h30);
    send_levels(6'h3F);
    settle();

    // reset values put back
    set_timing(10, 1000);
    run_mix(200);
    settle();

    set_timing(0, 1);
    // long receiver hold-off while the sender keeps pushing presses
    holdoff_asked++;
    calm = 1'b1;
    repeat (30) key_press_run();
    calm = 1'b0;
    run_mix(200);
    settle();

    set_timing(3, 12);
    run_mix(150);
    settle();
    run_mix(150);
    settle();

    // largest long-press limit
    set_timing(1, 65535);
    run_mix(100);
    settle();

    set_timing(255, 40);
    run_mix(300);
    settle();

    set_timing(5, 0);
    run_mix(150);
    settle();

    repeat (3) begin
      set_timing($urandom_range(0, 12), $urandom_range(1, 60));
      run_mix(150);
      settle();
    end

    repeat (8) @(posedge clk);
    if (board.expected_codes.size() != 0)
      board.report($sformatf("%0d key codes never came out", board.expected_codes.size()));
    $display("Covered %0d key ticks over %0d timing settings, with a long receiver hold-off.",
             board.ticks_seen, settings_used);
    $display("Codes up/down/left/right/tl/tr/tr-long: %0d %0d %0d %0d %0d %0d %0d",
             board.code_hits[0], board.code_hits[1], board.code_hits[2], board.code_hits[3],
             board.code_hits[4], board.code_hits[5], board.code_hits[6]);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
design/kdlp_pkg.sv
design/kdlp_fsm.sv
design/kdlp_out_buf.sv
design/keypad_debounce_long_press_core.sv
bench/keypad_debounce_long_press_core_tb.sv
